FILE: design/ffbp_pkg.sv
// Package for the first-fit bin packer: sizes, status codes and the
// transaction structs of the item and result channels. No dependencies.
package ffbp_pkg;

  // Number of bins and derived widths
  localparam int unsigned NumBins = 64;
  localparam int unsigned IdxW    = (NumBins > 1) ? $clog2(NumBins) : 1;
  localparam int unsigned CntW    = $clog2(NumBins + 1);

  // Fixed field widths of the channels
  localparam int unsigned WeightW  = 16;
  localparam int unsigned BinIdxW  = 6;
  localparam int unsigned InUseW   = 7;

  // Result status codes
  typedef enum logic [1:0] {
    ST_PLACED = 2'd0,
    ST_NEW    = 2'd1,
    ST_HEAVY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Input transaction
  typedef struct packed {
    logic [WeightW-1:0] item_weight;
    logic               last_of_set;
  } ffbp_item_t;

  // Result transaction
  typedef struct packed {
    logic [BinIdxW-1:0] bin_index;
    status_e            status;
    logic [InUseW-1:0]  bins_in_use;
  } ffbp_result_t;

endpackage

FILE: design/first_fit_bin_packer.sv
// First-fit bin packer, top level: sequencer, bin space memory and the
// shared subtract/compare unit. Depends on ffbp_pkg.
//
// Usage:
//   Item channel: drive item_i and raise start; the transaction is taken at
//   a rising edge with start high and busy low. busy stays high while the
//   item is worked on.
//   Result channel: result_valid_o is high for exactly one cycle with the
//   result on result_o. The receiver cannot stall; it must take it then.
//   Configuration: cfg_we_i writes cfg_wdata_i to the bin capacity; write
//   only while idle. The value applies to bins opened afterwards.
// Operation:
//   The weight is first checked against the capacity; then the scan reads
//   one open bin per cycle from the space memory, with the read data
//   registered before the compare. An item placed in bin k gets its result
//   once bin k is compared; a new bin or no-bin result comes once all
//   bins open before the item are scanned. A too-heavy item gets its result
//   from the check, without a scan. The next item can be accepted in the
//   cycle of the strobe.
// Reset:
//   Clears the open bin count and the sequencer and sets the capacity to
//   65535. Bin memory is not cleared; only written entries are compared.
module first_fit_bin_packer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  ffbp_pkg::ffbp_item_t   item_i,
  input  logic                   cfg_we_i,
  input  logic [15:0]            cfg_wdata_i,
  output logic                   result_valid_o,
  output ffbp_pkg::ffbp_result_t result_o
);
  import ffbp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_SCAN  = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [WeightW-1:0] cap_q;
  logic [WeightW-1:0] weight_q;
  logic               last_q;
  logic [WeightW-1:0] newspace_q, newspace_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    iss_q, iss_d;
  logic               chk_v_q, chk_v_d;
  logic [IdxW-1:0]    chk_idx_q, chk_idx_d;
  logic               res_v_q, res_v_d;
  ffbp_result_t       res_q, res_d;

  // Bin space memory
  logic [WeightW-1:0] mem [NumBins];
  logic [WeightW-1:0] rdata_q;
  logic               mem_we;
  logic [IdxW-1:0]    mem_waddr;
  logic [WeightW-1:0] mem_wdata;

  // Shared subtract/compare unit
  logic [WeightW-1:0] sub_a;
  logic [WeightW:0]   diff;
  logic               fits;

  assign sub_a = (state_q == S_SCAN) ? rdata_q : cap_q;
  assign diff  = {1'b0, sub_a} - {1'b0, weight_q};
  assign fits  = ~diff[WeightW];

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    newspace_d = newspace_q;
    count_d    = count_q;
    iss_d      = iss_q;
    chk_v_d    = chk_v_q;
    chk_idx_d  = chk_idx_q;
    res_v_d    = 1'b0;
    res_d      = res_q;
    mem_we     = 1'b0;
    mem_waddr  = chk_idx_q;
    mem_wdata  = diff[WeightW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        newspace_d = diff[WeightW-1:0];
        iss_d      = '0;
        chk_v_d    = 1'b0;
        if (!fits) begin
          res_v_d           = 1'b1;
          res_d.bin_index   = '0;
          res_d.status      = ST_HEAVY;
          res_d.bins_in_use = InUseW'(count_q);
          if (last_q) begin
            count_d = '0;
          end
          state_d = S_IDLE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (chk_v_q && fits) begin
          // hit: take space from the checked bin
          mem_we            = 1'b1;
          mem_waddr         = chk_idx_q;
          mem_wdata         = diff[WeightW-1:0];
          res_v_d           = 1'b1;
          res_d.bin_index   = BinIdxW'(chk_idx_q);
          res_d.status      = ST_PLACED;
          res_d.bins_in_use = InUseW'(count_q);
          count_d           = last_q ? '0 : count_q;
          state_d           = S_IDLE;
        end else if (iss_q != count_q) begin
          // read the next open bin
          chk_v_d   = 1'b1;
          chk_idx_d = iss_q[IdxW-1:0];
          iss_d     = iss_q + 1'b1;
        end else begin
          // no open bin fits
          res_v_d = 1'b1;
          state_d = S_IDLE;
          if (count_q != CntW'(NumBins)) begin
            mem_we            = 1'b1;
            mem_waddr         = count_q[IdxW-1:0];
            mem_wdata         = newspace_q;
            res_d.bin_index   = BinIdxW'(count_q);
            res_d.status      = ST_NEW;
            res_d.bins_in_use = InUseW'(count_q + 1'b1);
            count_d           = last_q ? '0 : count_q + 1'b1;
          end else begin
            res_d.bin_index   = '0;
            res_d.status      = ST_FULL;
            res_d.bins_in_use = InUseW'(count_q);
            count_d           = last_q ? '0 : count_q;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      res_v_q <= 1'b0;
      chk_v_q <= 1'b0;
      iss_q   <= '0;
      cap_q   <= '1;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      res_v_q <= res_v_d;
      chk_v_q <= chk_v_d;
      iss_q   <= iss_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      weight_q <= item_i.item_weight;
      last_q   <= item_i.last_of_set;
    end
    newspace_q <= newspace_d;
    chk_idx_q  <= chk_idx_d;
    res_q      <= res_d;
  end

  // Memory: at most one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[iss_q[IdxW-1:0]];
  end

endmodule

FILE: tb/sv/first_fit_bin_packer_tb.sv
// Testbench for first_fit_bin_packer: a directed table, then random item sets
// checked against an in-bench first-fit placement predictor. Needs ffbp_pkg.
`timescale 1ns / 100ps

module first_fit_bin_packer_tb;
  import ffbp_pkg::*;

  // Kinds of random item sets
  typedef enum int {
    SET_MIXED,
    SET_FILL,
    SET_NOISE
  } set_kind_e;

  // One line of the directed table: a capacity write or an item
  typedef struct packed {
    logic               is_cfg;
    logic [WeightW-1:0] value;
    logic               last;
    logic               typed;
    ffbp_result_t       want;
  } plan_row_t;

  localparam ffbp_result_t NoCheck = '0;
  localparam int PlanLen = 24;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         start;
  logic         busy;
  ffbp_item_t   item_i;
  logic         cfg_we_i;
  logic [15:0]  cfg_wdata_i;
  logic         result_valid_o;
  ffbp_result_t result_o;

  // Predictor state
  logic [WeightW-1:0] space_left [NumBins];
  int unsigned        bins_open = 0;
  logic [WeightW-1:0] capacity  = 16'hFFFF;

  ffbp_result_t placement_q [$];
  int           bad_count = 0;
  int           idle_pct  = 12;

  // Directed table: extremes, placed, new and too-heavy status, zero capacity, error on last item
  plan_row_t plan_rows [PlanLen] = '{
    '{1'b1, 16'hFFFF, 1'b0, 1'b0, NoCheck},
    '{1'b0, 16'h0000, 1'b0, 1'b1, '{6'd0, ST_NEW,    7'd1}},
    '{1'b0, 16'hFFFF, 1'b0, 1'b1, '{6'd0, ST_PLACED, 7'd1}},
    '{1'b0, 16'h0001, 1'b0, 1'b1, '{6'd1, ST_NEW,    7'd2}},
    '{1'b0, 16'hFFFF, 1'b1, 1'b1, '{6'd2, ST_NEW,    7'd3}},
    '{1'b0, 16'hFFFF, 1'b0, 1'b1, '{6'd0, ST_NEW,    7'd1}},
    '{1'b0, 16'h0000, 1'b1, 1'b1, '{6'd0, ST_PLACED, 7'd1}},
    '{1'b0, 16'h5555, 1'b0, 1'b0, NoCheck},
    '{1'b0, 16'hAAAA, 1'b0, 1'b0, NoCheck},
    '{1'b0, 16'h5556, 1'b0, 1'b0, NoCheck},
    '{1'b0, 16'h0001, 1'b1, 1'b0, NoCheck},
    '{1'b1, 16'h0001, 1'b0, 1'b0, NoCheck},
    '{1'b0, 16'h0002, 1'b0, 1'b1, '{6'd0, ST_HEAVY,  7'd0}},
    '{1'b0, 16'h0001, 1'b0, 1'b1, '{6'd0, ST_NEW,    7'd1}},
    '{1'b0, 16'h0001, 1'b0, 1'b1, '{6'd1, ST_NEW,    7'd2}},
    '{1'b0, 16'h0000, 1'b0, 1'b1, '{6'd0, ST_PLACED, 7'd2}},
    '{1'b0, 16'hFFFF, 1'b1, 1'b1, '{6'd0, ST_HEAVY,  7'd2}},
    '{1'b0, 16'h0000, 1'b0, 1'b1, '{6'd0, ST_NEW,    7'd1}},
    '{1'b1, 16'h0000, 1'b0, 1'b0, NoCheck},
    '{1'b0, 16'h0000, 1'b0, 1'b1, '{6'd0, ST_PLACED, 7'd1}},
    '{1'b0, 16'h0001, 1'b0, 1'b1, '{6'd0, ST_HEAVY,  7'd1}},
    '{1'b0, 16'h0000, 1'b1, 1'b1, '{6'd0, ST_PLACED, 7'd1}},
    '{1'b0, 16'h0000, 1'b1, 1'b1, '{6'd0, ST_NEW,    7'd1}},
    '{1'b0, 16'h8000, 1'b1, 1'b1, '{6'd0, ST_HEAVY,  7'd0}}
  };

  first_fit_bin_packer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // First-fit placement of one item; updates the bin state
  function automatic ffbp_result_t place_item(input ffbp_item_t it);
    ffbp_result_t r;
    logic         found;
    r     = '0;
    found = 1'b0;
    if (it.item_weight > capacity) begin
      r.status = ST_HEAVY;
    end else begin
      for (int k = 0; k < bins_open; k++) begin
        if (!found && space_left[k] >= it.item_weight) begin
          space_left[k] = space_left[k] - it.item_weight;
          r.bin_index   = BinIdxW'(k);
          found         = 1'b1;
        end
      end
      if (found) begin
        r.status = ST_PLACED;
      end else if (bins_open < NumBins) begin
        r.bin_index           = BinIdxW'(bins_open);
        space_left[bins_open] = capacity - it.item_weight;
        bins_open++;
        r.status = ST_NEW;
      end else begin
        r.status = ST_FULL;
      end
    end
    r.bins_in_use = InUseW'(bins_open);
    if (it.last_of_set) bins_open = 0;
    return r;
  endfunction

  // Weight for the next random item, shaped by the set kind
  function automatic logic [15:0] pick_weight(input set_kind_e kind);
    int unsigned c;
    int unsigned r;
    c = capacity;
    r = $urandom_range(0, 99);
    if (kind == SET_NOISE) return 16'($urandom);
    // each weight above half the capacity needs a bin of its own
    if (kind == SET_FILL) return 16'($urandom_range(c / 2 + 1, c));
    if (r < 8) return (c == 65535) ? 16'($urandom) : 16'($urandom_range(c + 1, 65535));
    if (r < 16) return r[0] ? 16'(c) : 16'd0;
    if (r < 60) return 16'($urandom_range(0, c / 4));
    return 16'($urandom_range(0, c));
  endfunction

  function automatic logic [15:0] pick_capacity();
    case ($urandom_range(0, 7))
      0:       return 16'hFFFF;
      1:       return 16'd1;
      2:       return 16'($urandom_range(2, 15));
      3:       return 16'($urandom_range(16, 1023));
      6:       return 16'h8000;
      7:       return 16'($urandom_range(60000, 65535));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    if (bad_count < 10) $display("[%0t] ERROR: %s", $time, what);
    bad_count++;
  endtask

  // Capacity write, only once the block has drained
  task automatic write_capacity(input logic [15:0] value);
    start <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    capacity  = value;
  endtask

  // One item transaction; start stays high unless an idle gap follows
  task automatic send_item(input logic [15:0] weight, input logic last,
                           input logic typed, input ffbp_result_t want);
    ffbp_item_t   it;
    ffbp_result_t predicted;
    it.item_weight = weight;
    it.last_of_set = last;
    item_i <= it;
    start  <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = place_item(it);
    placement_q.push_back(typed ? want : predicted);
    if ($urandom_range(0, 99) < idle_pct) begin
      start  <= 1'b0;
      item_i <= ffbp_item_t'($urandom);
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  // Result checker: every strobe must match the oldest prediction
  always @(posedge clk_i) begin : check_results
    ffbp_result_t want;
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      if (placement_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result bin %0d status %0d in_use %0d",
                                result_o.bin_index, result_o.status,
                                result_o.bins_in_use));
      end else begin
        want = placement_q.pop_front();
        if (result_o.bin_index !== want.bin_index || result_o.status !== want.status ||
            result_o.bins_in_use !== want.bins_in_use) begin
          flag_mismatch($sformatf(
            "bin/status/in_use expected %0d/%0d/%0d got %0d/%0d/%0d",
            want.bin_index, want.status, want.bins_in_use,
            result_o.bin_index, result_o.status, result_o.bins_in_use));
        end
      end
    end
  end

  // Stimulus
  initial begin
    set_kind_e kind;
    int        len;
    int        sent;
    logic      last;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (plan_rows[i]) begin
      if (plan_rows[i].is_cfg) begin
        write_capacity(plan_rows[i].value);
      end else begin
        send_item(plan_rows[i].value, plan_rows[i].last, plan_rows[i].typed,
                  plan_rows[i].want);
      end
    end

    // random sets: sender idles 12%, then 86%, then never
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 12 : (ph == 1) ? 86 : 0;
      sent     = 0;
      while (sent < 400) begin
        write_capacity(pick_capacity());
        repeat ($urandom_range(1, 4)) begin
          // the first set of each phase always fills every bin
          if (sent == 0) begin
            kind = SET_FILL;
          end else begin
            case ($urandom_range(0, 9))
              6, 7:    kind = SET_FILL;
              8:       kind = SET_NOISE;
              default: kind = SET_MIXED;
            endcase
          end
          case (kind)
            SET_FILL:  len = $urandom_range(64, 72);
            SET_NOISE: len = $urandom_range(1, 8);
            default:   len = $urandom_range(1, 24);
          endcase
          for (int n = 0; n < len; n++) begin
            last = (n == len - 1) || (kind == SET_NOISE && $urandom_range(0, 3) == 0);
            send_item(pick_weight(kind), last, 1'b0, NoCheck);
            sent++;
          end
        end
      end
    end

    // drain, then leave room for any stray strobe
    start <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk_i);
    repeat (NumBins + 8) @(posedge clk_i);
    if (bad_count == 0 && placement_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
